// ===== rtl/core/mmp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared types and constants for the 2x2 modular matrix power block.
// ----------------------------------------------------------------------------
package mmp_pkg;

    localparam int ENTRY_W = 32;
    localparam int EXP_W   = 32;
    localparam int MODIN_W = 31;
    localparam int RES_W   = 31;
    localparam int STEP_W  = 6;

    localparam logic [ENTRY_W-1:0] MULT_MSB_ONE = {1'b1, {(ENTRY_W-1){1'b0}}};

    typedef struct packed {
        logic              start;
        logic              dbl;
        logic [STEP_W-1:0] steps;
    } t_unit_cmd;

endpackage

// ===== rtl/core/matrix_2x2_modular_power.sv =====
// ----------------------------------------------------------------------------
// matrix_2x2_modular_power
// Raises a 2x2 matrix to an exponent modulo a modulus.
// ----------------------------------------------------------------------------
// Usage: drive the four entries, the exponent and the modulus and raise start
// while busy is low; that edge transfers the item. busy stays high until the
// answer is ready. The result then sits on o_result_* for exactly one cycle
// with o_valid high; the receiver cannot stall it and must take it then.
// A new item may be started in the same cycle that o_valid is shown.
// A modulus of zero is taken as 2^MOD_BITS.
// Operation: all work goes through one bit-serial modular unit that handles one
// multiplier bit per cycle. A matrix product takes eight modular products and
// four modular additions. The four entries are first reduced modulo the
// modulus; then every exponent bit up to the highest set one costs up to two
// matrix products. Exponent zero needs only the reduction. One item is in
// work at a time.
// Reset: synchronous, active low; clears the sequencer, busy and o_valid.
// ----------------------------------------------------------------------------
module matrix_2x2_modular_power #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mmp_pkg::ENTRY_W-1:0]  i_entry_00,
    input  logic [mmp_pkg::ENTRY_W-1:0]  i_entry_01,
    input  logic [mmp_pkg::ENTRY_W-1:0]  i_entry_10,
    input  logic [mmp_pkg::ENTRY_W-1:0]  i_entry_11,
    input  logic [mmp_pkg::EXP_W-1:0]    i_exponent,
    input  logic [mmp_pkg::MODIN_W-1:0]  i_modulus,
    output logic                         o_valid,
    output logic [mmp_pkg::RES_W-1:0]    o_result_00,
    output logic [mmp_pkg::RES_W-1:0]    o_result_01,
    output logic [mmp_pkg::RES_W-1:0]    o_result_10,
    output logic [mmp_pkg::RES_W-1:0]    o_result_11
);

    localparam int IW  = $clog2(EXP_BITS + 1);
    localparam int PAD = mmp_pkg::ENTRY_W - MOD_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SHF  = 3'd4;
    localparam logic [2:0] S_SQR  = 3'd5;

    localparam logic [1:0] PH_MUL0 = 2'd0;
    localparam logic [1:0] PH_MUL1 = 2'd1;
    localparam logic [1:0] PH_ADD  = 2'd2;

    logic [2:0]                  r_state;
    logic                        r_go;
    logic                        r_valid;
    logic [1:0]                  r_e;
    logic [1:0]                  r_ph;
    logic [IW-1:0]               r_iter;
    logic [mmp_pkg::EXP_W-1:0]   r_rem;
    logic [MOD_BITS:0]           r_mod;
    logic [mmp_pkg::ENTRY_W-1:0] r_raw  [4];
    logic [MOD_BITS-1:0]         r_base [4];
    logic [MOD_BITS-1:0]         r_acc  [4];
    logic [MOD_BITS-1:0]         r_c    [4];
    logic [MOD_BITS-1:0]         r_p0;
    logic [MOD_BITS-1:0]         r_p1;
    logic [MOD_BITS-1:0]         r_res  [4];

    logic                        s_accept;
    logic [MOD_BITS:0]           s_mod_in;
    logic [MOD_BITS-1:0]         s_one;
    logic                        s_sqr;
    logic [MOD_BITS-1:0]         s_x0;
    logic [MOD_BITS-1:0]         s_x1;
    logic [MOD_BITS-1:0]         s_y0;
    logic [MOD_BITS-1:0]         s_y1;
    mmp_pkg::t_unit_cmd          s_cmd;
    logic [MOD_BITS-1:0]         s_init;
    logic [MOD_BITS-1:0]         s_addend;
    logic [mmp_pkg::ENTRY_W-1:0] s_mult;
    logic                        s_done;
    logic [MOD_BITS-1:0]         s_ures;

    assign s_accept = start && !busy;
    assign s_mod_in = (i_modulus[MOD_BITS-1:0] == '0) ?
                      {1'b1, {MOD_BITS{1'b0}}} : {1'b0, i_modulus[MOD_BITS-1:0]};
    assign s_one    = (s_mod_in == (MOD_BITS+1)'(1)) ? '0 : MOD_BITS'(1);

    assign s_sqr = (r_state == S_SQR);
    assign s_x0  = s_sqr ? r_base[{r_e[1], 1'b0}] : r_acc[{r_e[1], 1'b0}];
    assign s_x1  = s_sqr ? r_base[{r_e[1], 1'b1}] : r_acc[{r_e[1], 1'b1}];
    assign s_y0  = r_base[{1'b0, r_e[0]}];
    assign s_y1  = r_base[{1'b1, r_e[0]}];

    always_comb begin
        s_cmd.start = r_go;
        s_cmd.dbl   = 1'b1;
        s_cmd.steps = mmp_pkg::STEP_W'(MOD_BITS);
        s_init      = '0;
        s_addend    = s_x0;
        s_mult      = {s_y0, {PAD{1'b0}}};
        if (r_state == S_RED) begin
            s_cmd.steps = mmp_pkg::STEP_W'(mmp_pkg::ENTRY_W);
            s_addend    = MOD_BITS'(1);
            s_mult      = r_raw[r_e];
        end else begin
            case (r_ph)
                PH_MUL0: begin
                    s_addend = s_x0;
                    s_mult   = {s_y0, {PAD{1'b0}}};
                end
                PH_MUL1: begin
                    s_addend = s_x1;
                    s_mult   = {s_y1, {PAD{1'b0}}};
                end
                PH_ADD: begin
                    s_cmd.dbl   = 1'b0;
                    s_cmd.steps = mmp_pkg::STEP_W'(1);
                    s_init      = r_p0;
                    s_addend    = r_p1;
                    s_mult      = mmp_pkg::MULT_MSB_ONE;
                end
                default: begin
                    s_addend = s_x0;
                end
            endcase
        end
    end

    mmp_modunit #(
        .MOD_BITS (MOD_BITS)
    ) u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (s_cmd),
        .i_init   (s_init),
        .i_addend (s_addend),
        .i_mult   (s_mult),
        .i_mod    (r_mod),
        .o_done   (s_done),
        .o_res    (s_ures)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_go    <= 1'b0;
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_state <= S_RED;
                        r_go    <= 1'b1;
                    end
                end
                S_RED: begin
                    if (s_done) begin
                        if (r_e == 2'd3) begin
                            r_state <= S_CHK;
                        end else begin
                            r_go <= 1'b1;
                        end
                    end
                end
                S_CHK: begin
                    if (r_rem == '0 || r_iter == IW'(EXP_BITS)) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end else if (r_rem[0]) begin
                        r_state <= S_MUL;
                        r_go    <= 1'b1;
                    end else begin
                        r_state <= S_SHF;
                    end
                end
                S_MUL, S_SQR: begin
                    if (s_done) begin
                        if (r_ph == PH_ADD && r_e == 2'd3) begin
                            r_state <= s_sqr ? S_CHK : S_SHF;
                        end else begin
                            r_go <= 1'b1;
                        end
                    end
                end
                S_SHF: begin
                    if (r_rem[mmp_pkg::EXP_W-1:1] != '0) begin
                        r_state <= S_SQR;
                        r_go    <= 1'b1;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    r_raw[0] <= i_entry_00;
                    r_raw[1] <= i_entry_01;
                    r_raw[2] <= i_entry_10;
                    r_raw[3] <= i_entry_11;
                    r_rem    <= i_exponent;
                    r_mod    <= s_mod_in;
                    r_iter   <= '0;
                    r_e      <= 2'd0;
                    r_ph     <= PH_MUL0;
                    r_acc[0] <= s_one;
                    r_acc[1] <= '0;
                    r_acc[2] <= '0;
                    r_acc[3] <= s_one;
                end
            end
            S_RED: begin
                if (s_done) begin
                    r_base[r_e] <= s_ures;
                    r_e         <= r_e + 2'd1;
                end
            end
            S_CHK: begin
                r_e  <= 2'd0;
                r_ph <= PH_MUL0;
                for (int i = 0; i < 4; i++) begin
                    r_res[i] <= r_acc[i];
                end
            end
            S_MUL, S_SQR: begin
                if (s_done) begin
                    case (r_ph)
                        PH_MUL0: begin
                            r_p0 <= s_ures;
                            r_ph <= PH_MUL1;
                        end
                        PH_MUL1: begin
                            r_p1 <= s_ures;
                            r_ph <= PH_ADD;
                        end
                        default: begin
                            r_c[r_e] <= s_ures;
                            r_ph     <= PH_MUL0;
                            r_e      <= r_e + 2'd1;
                            if (r_e == 2'd3) begin
                                if (s_sqr) begin
                                    r_base[0] <= r_c[0];
                                    r_base[1] <= r_c[1];
                                    r_base[2] <= r_c[2];
                                    r_base[3] <= s_ures;
                                end else begin
                                    r_acc[0] <= r_c[0];
                                    r_acc[1] <= r_c[1];
                                    r_acc[2] <= r_c[2];
                                    r_acc[3] <= s_ures;
                                end
                            end
                        end
                    endcase
                end
            end
            S_SHF: begin
                r_rem  <= r_rem >> 1;
                r_iter <= r_iter + IW'(1);
                r_e    <= 2'd0;
                r_ph   <= PH_MUL0;
            end
            default: begin
                r_e <= 2'd0;
            end
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_result_00 = mmp_pkg::RES_W'(r_res[0]);
    assign o_result_01 = mmp_pkg::RES_W'(r_res[1]);
    assign o_result_10 = mmp_pkg::RES_W'(r_res[2]);
    assign o_result_11 = mmp_pkg::RES_W'(r_res[3]);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> busy)
        else $error("busy not raised after transfer");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_unit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.start |-> busy)
        else $error("unit started while idle");

    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((MOD_BITS+1)'(r_res[0]) < r_mod && (MOD_BITS+1)'(r_res[3]) < r_mod))
        else $error("result entry not reduced");

endmodule

// ===== rtl/core/mmp_modunit.sv =====
// ----------------------------------------------------------------------------
// mmp_modunit
// Shared bit-serial modular unit: r = (dbl ? 2r : r) + bit * a, reduced
// modulo m, one multiplier bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mmp_modunit #(
    parameter int MOD_BITS = 31
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mmp_pkg::t_unit_cmd         i_cmd,
    input  logic [MOD_BITS-1:0]        i_init,
    input  logic [MOD_BITS-1:0]        i_addend,
    input  logic [mmp_pkg::ENTRY_W-1:0] i_mult,
    input  logic [MOD_BITS:0]          i_mod,
    output logic                       o_done,
    output logic [MOD_BITS-1:0]        o_res
);

    localparam int TW = MOD_BITS + 2;

    logic [mmp_pkg::STEP_W-1:0]   r_cnt, n_cnt;
    logic                         r_done, n_done;
    logic [MOD_BITS-1:0]          r_r, n_r;
    logic [MOD_BITS-1:0]          r_a, n_a;
    logic [mmp_pkg::ENTRY_W-1:0]  r_b, n_b;
    logic                         r_dbl, n_dbl;

    logic [TW-1:0] s_base;
    logic [TW-1:0] s_sum;
    logic [TW-1:0] s_m1;
    logic [TW-1:0] s_m2;
    logic [TW-1:0] s_red;

    always_comb begin
        s_base = r_dbl ? {1'b0, r_r, 1'b0} : {2'b00, r_r};
        s_sum  = s_base + (r_b[mmp_pkg::ENTRY_W-1] ? {2'b00, r_a} : {TW{1'b0}});
        s_m1   = {1'b0, i_mod};
        s_m2   = {i_mod, 1'b0};
        if (s_sum >= s_m2) begin
            s_red = s_sum - s_m2;
        end else if (s_sum >= s_m1) begin
            s_red = s_sum - s_m1;
        end else begin
            s_red = s_sum;
        end
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_r    = r_r;
        n_a    = r_a;
        n_b    = r_b;
        n_dbl  = r_dbl;
        if (i_cmd.start) begin
            n_cnt = i_cmd.steps;
            n_r   = i_init;
            n_a   = i_addend;
            n_b   = i_mult;
            n_dbl = i_cmd.dbl;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - mmp_pkg::STEP_W'(1);
            n_r    = s_red[MOD_BITS-1:0];
            n_b    = {r_b[mmp_pkg::ENTRY_W-2:0], 1'b0};
            n_done = (r_cnt == mmp_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r   <= n_r;
        r_a   <= n_a;
        r_b   <= n_b;
        r_dbl <= n_dbl;
    end

    assign o_done = r_done;
    assign o_res  = r_r;

endmodule
